// ===== rtl/core/cac_pkg.sv =====
package cac_pkg;

    localparam int IDX_W = 3;
    localparam int WR_DATA_W = 20;

    localparam logic [IDX_W-1:0] REG_CLIMB_RATE_LIMIT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_DESCENT_RATE_LIMIT = 3'd1;
    localparam logic [IDX_W-1:0] REG_ACTIVE_VARIANCE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_STILL_VARIANCE     = 3'd3;
    localparam logic [IDX_W-1:0] REG_FALL_ACCEL         = 3'd4;
    localparam logic [IDX_W-1:0] REG_CONFIRM_TICKS      = 3'd5;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLIMB = 3'd1;
    localparam logic [2:0] ST_DESC  = 3'd2;
    localparam logic [2:0] ST_REST  = 3'd3;
    localparam logic [2:0] ST_FALL  = 3'd4;

    localparam logic signed [15:0] GROUND_LIMIT = -16'sd60;
    localparam logic [7:0] CONFIRM_MAX = 8'd255;

    typedef struct packed {
        logic [14:0] climb_rate_limit;
        logic [14:0] descent_rate_limit;
        logic [19:0] active_variance;
        logic [19:0] still_variance;
        logic [15:0] fall_accel;
        logic [7:0]  confirm_ticks;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic [19:0]        accel_variance;
        logic signed [15:0] pressure_rate;
        logic [15:0]        total_accel;
        logic signed [15:0] pressure_rel;
    } item_t;

    typedef struct packed {
        logic [2:0]  current_state;
        logic [2:0]  pending_state;
        logic [7:0]  confirm_count;
        logic [19:0] climb_peak_variance;
        logic        attempt_was_counted;
        logic        fresh_session;
    } track_t;

endpackage

// ===== rtl/core/climb_activity_classifier.sv =====
// Channel   | handshake           | payload
// input     | in_valid, in_stall  | action, accel_variance, pressure_rate, total_accel,
//           |                     | pressure_rel
// output    | out_valid, out_stall| activity_state, attempt_count, state_changed
// config    | wr_en               | wr_index, wr_data
//
// A transaction is registered on entry and classified from the input register into the
// result registers; an output stall can hold it in the input register between the two.
// One transaction is taken every cycle while in_stall is low. The session state is
// held in one set of registers updated by a combinational classification step, which
// sets that rate. Reset clears the session state and loads the register defaults.
// While a result is stalled the input register holds one more transaction, then
// in_stall is raised.
module climb_activity_classifier #(
    parameter int FALL_TICKS   = 5,
    parameter int ATTEMPT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [19:0]                   accel_variance,
    input  logic signed [15:0]            pressure_rate,
    input  logic [15:0]                   total_accel,
    input  logic signed [15:0]            pressure_rel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    activity_state,
    output logic [15:0]                   attempt_count,
    output logic                          state_changed,
    input  logic                          wr_en,
    input  logic [cac_pkg::IDX_W-1:0]     wr_index,
    input  logic [cac_pkg::WR_DATA_W-1:0] wr_data
);
    import cac_pkg::*;

    localparam int FALL_W = $clog2(FALL_TICKS + 1);

    cfg_t                    cfg;
    logic                    s1_valid_reg;
    item_t                   s1_item_reg;
    track_t                  track_reg;
    track_t                  track_next;
    logic [FALL_W-1:0]       fall_count_reg;
    logic [FALL_W-1:0]       fall_count_next;
    logic [ATTEMPT_BITS-1:0] attempts_reg;
    logic [ATTEMPT_BITS-1:0] attempts_next;
    logic                    out_valid_reg;
    logic [2:0]              state_reg;
    logic [15:0]             count_reg;
    logic                    changed_reg;
    logic [15:0]             count_shown;
    logic                    advance;
    logic                    s1_fire;
    logic                    in_take;

    cac_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    cac_classify #(
        .FALL_TICKS   (FALL_TICKS),
        .ATTEMPT_BITS (ATTEMPT_BITS),
        .FALL_W       (FALL_W)
    ) u_classify (
        .item            (s1_item_reg),
        .cfg             (cfg),
        .track           (track_reg),
        .fall_count      (fall_count_reg),
        .attempts        (attempts_reg),
        .track_next      (track_next),
        .fall_count_next (fall_count_next),
        .attempts_next   (attempts_next)
    );

    generate
        if (ATTEMPT_BITS > 16)
        begin : g_sat
            assign count_shown = (|attempts_next[ATTEMPT_BITS-1:16]) ?
                                 16'hFFFF : attempts_next[15:0];
        end
        else
        begin : g_ext
            assign count_shown = 16'(attempts_next);
        end
    endgenerate

    assign advance  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.action         <= action;
            s1_item_reg.accel_variance <= accel_variance;
            s1_item_reg.pressure_rate  <= pressure_rate;
            s1_item_reg.total_accel    <= total_accel;
            s1_item_reg.pressure_rel   <= pressure_rel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg.current_state       <= ST_IDLE;
            track_reg.pending_state       <= ST_IDLE;
            track_reg.confirm_count       <= '0;
            track_reg.climb_peak_variance <= '0;
            track_reg.attempt_was_counted <= 1'b0;
            track_reg.fresh_session       <= 1'b0;
            fall_count_reg                <= '0;
            attempts_reg                  <= '0;
        end
        else if (s1_fire)
        begin
            track_reg      <= track_next;
            fall_count_reg <= fall_count_next;
            attempts_reg   <= attempts_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            state_reg   <= track_next.current_state;
            count_reg   <= count_shown;
            changed_reg <= track_next.current_state != track_reg.current_state;
        end
    end

    assign out_valid      = out_valid_reg;
    assign activity_state = state_reg;
    assign attempt_count  = count_reg;
    assign state_changed  = changed_reg;

    a_state_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> activity_state == track_reg.current_state)
        else $error("result state differs from the tracked state");

    a_fall_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fall_count_reg < FALL_W'(FALL_TICKS))
        else $error("free-fall counter reached its limit without firing");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_item_reg.action |=>
            activity_state == ST_IDLE && attempt_count == 16'd0 &&
            track_reg.fresh_session)
        else $error("start transaction did not clear the session");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

endmodule

// ===== rtl/core/cac_regs.sv =====
module cac_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [cac_pkg::IDX_W-1:0]  wr_index,
    input  logic [cac_pkg::WR_DATA_W-1:0] wr_data,
    output cac_pkg::cfg_t              cfg
);
    import cac_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.climb_rate_limit   <= 15'd30;
            cfg_reg.descent_rate_limit <= 15'd30;
            cfg_reg.active_variance    <= 20'd300;
            cfg_reg.still_variance     <= 20'd100;
            cfg_reg.fall_accel         <= 16'd300;
            cfg_reg.confirm_ticks      <= 8'd3;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CLIMB_RATE_LIMIT:   cfg_reg.climb_rate_limit   <= wr_data[14:0];
                REG_DESCENT_RATE_LIMIT: cfg_reg.descent_rate_limit <= wr_data[14:0];
                REG_ACTIVE_VARIANCE:    cfg_reg.active_variance    <= wr_data[19:0];
                REG_STILL_VARIANCE:     cfg_reg.still_variance     <= wr_data[19:0];
                REG_FALL_ACCEL:         cfg_reg.fall_accel         <= wr_data[15:0];
                REG_CONFIRM_TICKS:      cfg_reg.confirm_ticks      <= wr_data[7:0];
                default:                ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/cac_classify.sv =====
module cac_classify #(
    parameter int FALL_TICKS   = 5,
    parameter int ATTEMPT_BITS = 16,
    parameter int FALL_W       = $clog2(FALL_TICKS + 1)
) (
    input  cac_pkg::item_t          item,
    input  cac_pkg::cfg_t           cfg,
    input  cac_pkg::track_t         track,
    input  logic [FALL_W-1:0]       fall_count,
    input  logic [ATTEMPT_BITS-1:0] attempts,
    output cac_pkg::track_t         track_next,
    output logic [FALL_W-1:0]       fall_count_next,
    output logic [ATTEMPT_BITS-1:0] attempts_next
);
    import cac_pkg::*;

    localparam logic [ATTEMPT_BITS-1:0] ATTEMPT_MAX = {ATTEMPT_BITS{1'b1}};
    localparam logic [FALL_W-1:0] FALL_LIMIT = FALL_W'(FALL_TICKS);

    logic               active;
    logic               still;
    logic               up;
    logic               down;
    logic               near_ground;
    logic               fall_tick;
    logic signed [16:0] rate_x;
    logic [FALL_W-1:0]  fall_inc;
    logic [7:0]         confirm_inc;
    logic [19:0]        peak;
    logic [2:0]         target;

    assign rate_x      = {item.pressure_rate[15], item.pressure_rate};
    assign active      = item.accel_variance > cfg.active_variance;
    assign still       = item.accel_variance < cfg.still_variance;
    assign up          = rate_x < -$signed({2'b00, cfg.climb_rate_limit});
    assign down        = rate_x > $signed({2'b00, cfg.descent_rate_limit});
    assign near_ground = item.pressure_rel > GROUND_LIMIT;
    assign fall_tick   = item.total_accel < cfg.fall_accel;
    assign fall_inc    = fall_count + FALL_W'(1);
    assign confirm_inc = (track.confirm_count < CONFIRM_MAX) ?
                         track.confirm_count + 8'd1 : track.confirm_count;
    assign peak        = (track.current_state == ST_CLIMB &&
                          item.accel_variance > track.climb_peak_variance) ?
                         item.accel_variance : track.climb_peak_variance;

    always_comb
    begin
        if (up && active)
            target = ST_CLIMB;
        else if (down)
            target = ST_DESC;
        else if (still)
            target = ST_REST;
        else
            target = track.current_state;
    end

    always_comb
    begin
        track_next      = track;
        fall_count_next = fall_count;
        attempts_next   = attempts;
        if (item.action)
        begin
            track_next.current_state       = ST_IDLE;
            track_next.pending_state       = ST_IDLE;
            track_next.confirm_count       = '0;
            track_next.climb_peak_variance = '0;
            track_next.attempt_was_counted = 1'b0;
            track_next.fresh_session       = 1'b1;
            fall_count_next                = '0;
            attempts_next                  = '0;
        end
        else
        begin
            track_next.climb_peak_variance = peak;
            if (fall_tick)
            begin
                if (fall_inc >= FALL_LIMIT)
                begin
                    fall_count_next          = '0;
                    track_next.current_state = ST_FALL;
                    track_next.confirm_count = '0;
                end
                else
                begin
                    fall_count_next = fall_inc;
                end
            end
            else
            begin
                fall_count_next = '0;
                if (target != track.current_state)
                begin
                    if (target == track.pending_state)
                    begin
                        track_next.confirm_count = confirm_inc;
                        if (confirm_inc >= cfg.confirm_ticks)
                        begin
                            if (track.current_state == ST_CLIMB)
                            begin
                                if (track.attempt_was_counted &&
                                    peak < cfg.active_variance && attempts != '0)
                                    attempts_next = attempts - ATTEMPT_BITS'(1);
                                track_next.climb_peak_variance = '0;
                                track_next.attempt_was_counted = 1'b0;
                            end
                            if (target == ST_CLIMB)
                            begin
                                track_next.climb_peak_variance = '0;
                                track_next.attempt_was_counted = 1'b0;
                                if (near_ground)
                                begin
                                    if (attempts != ATTEMPT_MAX)
                                        attempts_next = attempts + ATTEMPT_BITS'(1);
                                    track_next.attempt_was_counted = 1'b1;
                                end
                            end
                            track_next.current_state = target;
                            track_next.confirm_count = '0;
                        end
                    end
                    else
                    begin
                        track_next.pending_state = target;
                        track_next.confirm_count = 8'd1;
                    end
                end
                else
                begin
                    track_next.confirm_count = '0;
                    track_next.pending_state = track.current_state;
                end
            end

            if (track.fresh_session)
            begin
                track_next.fresh_session = 1'b0;
                track_next.pending_state = ST_IDLE;
                track_next.confirm_count = '0;
                fall_count_next          = '0;
            end
        end
    end

endmodule

// ===== sim/climb_activity_monitor.sv =====
`timescale 1ns / 100ps

module climb_activity_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          action,
    input  logic [19:0]                   accel_variance,
    input  logic signed [15:0]            pressure_rate,
    input  logic [15:0]                   total_accel,
    input  logic signed [15:0]            pressure_rel,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [2:0]                    activity_state,
    input  logic [15:0]                   attempt_count,
    input  logic                          state_changed,
    input  logic                          wr_en,
    input  logic [cac_pkg::IDX_W-1:0]     wr_index,
    input  logic [cac_pkg::WR_DATA_W-1:0] wr_data,
    output int                            mismatches,
    output int                            outstanding
);
    import cac_pkg::*;

    localparam int FALL_RUN = 5;
    localparam logic [15:0] ATTEMPT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  activity;
        logic [15:0] attempts;
        logic        changed;
    } outcome_t;

    cfg_t        limits;
    logic [2:0]  cur_state;
    logic [2:0]  cand_state;
    logic [7:0]  agree_count;
    int          low_g_run;
    logic [19:0] peak_var;
    logic        attempt_open;
    logic [15:0] attempt_tally;
    logic        just_started;
    outcome_t    awaited_results[$];

    task automatic wipe_session();
        cur_state = ST_IDLE;
        cand_state = ST_IDLE;
        agree_count = '0;
        low_g_run = 0;
        peak_var = '0;
        attempt_open = 1'b0;
        attempt_tally = '0;
    endtask

    task automatic classify_tick(input logic act, input logic [19:0] variance,
                                 input logic signed [15:0] rate, input logic [15:0] total,
                                 input logic signed [15:0] rel, output outcome_t res);
        logic [2:0] prev;
        logic [2:0] target;
        logic       is_active;
        logic       is_still;
        logic       going_up;
        logic       going_down;
        prev = cur_state;
        if (act)
        begin
            wipe_session();
            just_started = 1'b1;
        end
        else
        begin
            is_active = variance > limits.active_variance;
            is_still = variance < limits.still_variance;
            going_up = int'(rate) < -int'(limits.climb_rate_limit);
            going_down = int'(rate) > int'(limits.descent_rate_limit);
            if (cur_state == ST_CLIMB && variance > peak_var)
                peak_var = variance;
            if (total < limits.fall_accel)
            begin
                low_g_run++;
                if (low_g_run >= FALL_RUN)
                begin
                    low_g_run = 0;
                    cur_state = ST_FALL;
                    agree_count = '0;
                end
            end
            else
            begin
                low_g_run = 0;
                target = cur_state;
                if (going_up && is_active)
                    target = ST_CLIMB;
                else if (going_down)
                    target = ST_DESC;
                else if (is_still)
                    target = ST_REST;
                if (target != cur_state)
                begin
                    if (target == cand_state)
                    begin
                        if (agree_count < CONFIRM_MAX)
                            agree_count++;
                        if (agree_count >= limits.confirm_ticks)
                        begin
                            if (cur_state == ST_CLIMB)
                            begin
                                if (attempt_open && peak_var < limits.active_variance
                                    && attempt_tally != 0)
                                    attempt_tally--;
                                peak_var = '0;
                                attempt_open = 1'b0;
                            end
                            if (target == ST_CLIMB)
                            begin
                                peak_var = '0;
                                attempt_open = 1'b0;
                                if (int'(rel) > int'(GROUND_LIMIT))
                                begin
                                    if (attempt_tally != ATTEMPT_MAX)
                                        attempt_tally++;
                                    attempt_open = 1'b1;
                                end
                            end
                            cur_state = target;
                            agree_count = '0;
                        end
                    end
                    else
                    begin
                        cand_state = target;
                        agree_count = 8'd1;
                    end
                end
                else
                begin
                    agree_count = '0;
                    cand_state = cur_state;
                end
            end
            if (just_started)
            begin
                just_started = 1'b0;
                cand_state = ST_IDLE;
                agree_count = '0;
                low_g_run = 0;
            end
        end
        res.activity = cur_state;
        res.attempts = attempt_tally;
        res.changed = (cur_state != prev);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        outcome_t next_res;
        if (!rst_n)
        begin
            limits = '{15'd30, 15'd30, 20'd300, 20'd100, 16'd300, 8'd3};
            wipe_session();
            just_started = 1'b0;
            awaited_results.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_CLIMB_RATE_LIMIT:   limits.climb_rate_limit = wr_data[14:0];
                    REG_DESCENT_RATE_LIMIT: limits.descent_rate_limit = wr_data[14:0];
                    REG_ACTIVE_VARIANCE:    limits.active_variance = wr_data[19:0];
                    REG_STILL_VARIANCE:     limits.still_variance = wr_data[19:0];
                    REG_FALL_ACCEL:         limits.fall_accel = wr_data[15:0];
                    REG_CONFIRM_TICKS:      limits.confirm_ticks = wr_data[7:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("Result transaction arrived with none outstanding.");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (activity_state !== want.activity)
                    begin
                        $error("activity_state: expected %0d, got %0d",
                               want.activity, activity_state);
                        mismatches++;
                    end
                    if (attempt_count !== want.attempts)
                    begin
                        $error("attempt_count: expected %0d, got %0d",
                               want.attempts, attempt_count);
                        mismatches++;
                    end
                    if (state_changed !== want.changed)
                    begin
                        $error("state_changed: expected %0d, got %0d",
                               want.changed, state_changed);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                classify_tick(action, accel_variance, pressure_rate, total_accel,
                              pressure_rel, next_res);
                awaited_results.push_back(next_res);
            end
            outstanding = awaited_results.size();
        end
    end

endmodule

// ===== sim/tb_climb_activity_classifier.sv =====
`timescale 1ns / 100ps

module tb_climb_activity_classifier;

    import cac_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 175;
    localparam int VAR_MAX = 1048575;

    typedef enum {
        RUN_CLIMB,
        RUN_DESCEND,
        RUN_REST,
        RUN_HOLD,
        RUN_FALL,
        RUN_NOISE,
        RUN_START
    } run_kind_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 action = 1'b0;
    logic [19:0]          accel_variance = '0;
    logic signed [15:0]   pressure_rate = '0;
    logic [15:0]          total_accel = '0;
    logic signed [15:0]   pressure_rel = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           activity_state;
    logic [15:0]          attempt_count;
    logic                 state_changed;
    logic                 wr_en = 1'b0;
    logic [IDX_W-1:0]     wr_index = REG_CLIMB_RATE_LIMIT;
    logic [WR_DATA_W-1:0] wr_data = '0;
    int                   mismatches;
    int                   outstanding;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    cfg_t                 cfg_now = '{15'd30, 15'd30, 20'd300, 20'd100, 16'd300, 8'd3};

    climb_activity_classifier #(
        .FALL_TICKS(5),
        .ATTEMPT_BITS(16)
    ) uut (.*);

    climb_activity_monitor activity_mon (.*);

    always #4 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    function automatic int clamp(int x, int lo, int hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    task automatic send_tick(input logic act, input logic [19:0] variance,
                             input logic [15:0] rate, input logic [15:0] total,
                             input logic [15:0] rel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        accel_variance <= variance;
        pressure_rate <= rate;
        total_accel <= total;
        pressure_rel <= rel;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_regs(input cfg_t c);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_CLIMB_RATE_LIMIT;
        wr_data <= WR_DATA_W'(c.climb_rate_limit);
        @(negedge clk);
        wr_index <= REG_DESCENT_RATE_LIMIT;
        wr_data <= WR_DATA_W'(c.descent_rate_limit);
        @(negedge clk);
        wr_index <= REG_ACTIVE_VARIANCE;
        wr_data <= WR_DATA_W'(c.active_variance);
        @(negedge clk);
        wr_index <= REG_STILL_VARIANCE;
        wr_data <= WR_DATA_W'(c.still_variance);
        @(negedge clk);
        wr_index <= REG_FALL_ACCEL;
        wr_data <= WR_DATA_W'(c.fall_accel);
        @(negedge clk);
        wr_index <= REG_CONFIRM_TICKS;
        wr_data <= WR_DATA_W'(c.confirm_ticks);
        @(negedge clk);
        wr_en <= 1'b0;
        cfg_now = c;
    endtask

    task automatic play_kind(input run_kind_t kind, input int len);
        int n;
        int variance;
        int rate;
        int total;
        int rel;
        int lo;
        int hi;
        for (n = 0; n < len; n++)
        begin
            if ($urandom_range(3) == 0)
                rel = int'($urandom_range(16'hFFFF)) - 32768;
            else
                rel = int'($urandom_range(40)) - 80;
            if (kind == RUN_FALL)
                total = (cfg_now.fall_accel == 0) ? 0 :
                        int'($urandom_range(cfg_now.fall_accel - 1));
            else
                total = clamp(int'(cfg_now.fall_accel) + int'($urandom_range(3000)) - 1,
                              0, 65535);
            rate = -int'(cfg_now.climb_rate_limit)
                   + int'($urandom_range(int'(cfg_now.climb_rate_limit)
                                         + int'(cfg_now.descent_rate_limit)));
            variance = int'($urandom_range(VAR_MAX));
            case (kind)
                RUN_CLIMB:
                begin
                    variance = clamp(int'(cfg_now.active_variance)
                                     + int'($urandom_range(4000)) - 2, 0, VAR_MAX);
                    rate = clamp(-int'(cfg_now.climb_rate_limit)
                                 - int'($urandom_range(800)) + 1, -32768, 32767);
                end
                RUN_DESCEND:
                    rate = clamp(int'(cfg_now.descent_rate_limit)
                                 + int'($urandom_range(800)) - 1, -32768, 32767);
                RUN_REST:
                    variance = int'($urandom_range(cfg_now.still_variance));
                RUN_HOLD:
                begin
                    lo = int'(cfg_now.still_variance);
                    hi = int'(cfg_now.active_variance);
                    variance = int'($urandom_range(lo, hi));
                end
                RUN_FALL:
                    rate = int'($urandom_range(16'hFFFF)) - 32768;
                default: ;
            endcase
            if (kind == RUN_START)
                send_tick(1'b1, 20'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else if (kind == RUN_NOISE)
                send_tick($urandom_range(15) == 0, 20'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
            else
                send_tick(1'b0, 20'(variance), 16'(rate), 16'(total), 16'(rel));
        end
    endtask

    task automatic play_run(output int len);
        int pick;
        run_kind_t kind;
        pick = $urandom_range(99);
        if (pick < 4)
            kind = RUN_START;
        else if (pick < 26)
            kind = RUN_CLIMB;
        else if (pick < 40)
            kind = RUN_DESCEND;
        else if (pick < 54)
            kind = RUN_REST;
        else if (pick < 70)
            kind = RUN_HOLD;
        else if (pick < 82)
            kind = RUN_FALL;
        else
            kind = RUN_NOISE;
        if (kind == RUN_START)
            len = 1;
        else if (kind == RUN_FALL)
            len = $urandom_range(1, 7);
        else if ($urandom_range(19) == 0)
            len = int'(cfg_now.confirm_ticks) + 2;
        else
            len = $urandom_range(1, 8);
        play_kind(kind, len);
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        int sent;
        int len;
        cfg_t next_cfg;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A tick before any session, then a start and its discarded first tick.
        send_tick(1'b0, 20'd0, 16'sd0, 16'd0, 16'sd0);
        send_tick(1'b1, 20'hFFFFF, 16'h8000, 16'hFFFF, 16'h7FFF);
        send_tick(1'b0, 20'hFFFFF, 16'h8000, 16'hFFFF, 16'h7FFF);
        repeat (3) send_tick(1'b0, 20'd500, -16'sd100, 16'd1000, 16'sd0);
        // A weak climb followed by a descent takes the attempt back.
        send_tick(1'b0, 20'd200, 16'sd0, 16'd1000, 16'sd0);
        repeat (3) send_tick(1'b0, 20'd200, 16'sd32767, 16'd1000, 16'sd0);
        repeat (5) send_tick(1'b0, 20'd0, 16'sd0, 16'd0, -16'sd32768);
        send_tick(1'b1, 20'd0, 16'sd0, 16'd0, 16'sd0);
        // Climbing entered exactly at the ground limit is not counted.
        repeat (4) send_tick(1'b0, 20'd900, -16'sd500, 16'd2000, -16'sd60);
        repeat (5) send_tick(1'b0, 20'd900, -16'sd500, 16'd10, -16'sd60);

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: next_cfg = '{15'd30, 15'd30, 20'd300, 20'd100, 16'd300, 8'd3};
                1: next_cfg = '{15'd0, 15'd0, 20'd0, 20'd0, 16'd0, 8'd0};
                2: next_cfg = '{15'h7FFF, 15'h7FFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 8'hFF};
                3: next_cfg = '{15'd50, 15'd20, 20'd800, 20'd200, 16'd500, 8'd1};
                default: next_cfg = '{15'($urandom_range(400)), 15'($urandom_range(400)),
                                      20'($urandom_range(3000)), 20'($urandom_range(1500)),
                                      16'($urandom_range(1200)), 8'($urandom_range(6))};
            endcase
            program_regs(next_cfg);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct = 28;
                    recv_stall_pct = 28;
                end
            endcase
            // With the longest confirmation a change needs a full run of agreeing ticks.
            if (p == 2)
                play_kind(RUN_REST, 258);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                play_run(len);
                sent += len;
            end
        end

        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cac_pkg.sv
rtl/core/cac_regs.sv
rtl/core/cac_classify.sv
rtl/core/climb_activity_classifier.sv
sim/climb_activity_monitor.sv
sim/tb_climb_activity_classifier.sv
